@@ rtl/stereo_sound_mixer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stereo sound mixer
// Shorthand for clocked implications, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef STEREO_SOUND_MIXER_ASSERT_SVH
`define STEREO_SOUND_MIXER_ASSERT_SVH

// Same-cycle implication.
`define SMIX_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stereo_sound_mixer: same-cycle check failed");

// Next-cycle implication.
`define SMIX_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stereo_sound_mixer: next-cycle check failed");

`endif

@@ rtl/smix_pkg.sv @@
// ----------------------------------------------------------------------------
// smix_pkg
// Types, register codes and arithmetic helpers shared by the mixer blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smix_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_VOLUME  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUTE           = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_8BIT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_STEREO  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_SIZE_LOG2 = 3'd4;

    localparam logic [8:0] MASTER_VOLUME_RESET  = 9'd179;
    localparam logic [8:0] UNITY_VOLUME         = 9'd256;
    localparam logic [4:0] RING_SIZE_LOG2_RESET = 5'd14;

    localparam logic signed [23:0] SUM_MAX = 24'sh7fffff;
    localparam logic signed [23:0] SUM_MIN = -24'sh800000;
    localparam logic signed [24:0] OUT_MAX = 25'sh007fff;
    localparam logic signed [24:0] OUT_MIN = -25'sh008000;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] sample;
        logic [7:0]         left_volume;
        logic [7:0]         right_volume;
        logic               last_in_frame;
    } item_t;

    typedef struct packed {
        logic [15:0]        address;
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } result_t;

    typedef struct packed {
        logic signed [16:0] contrib_l;
        logic signed [16:0] contrib_r;
        logic               last;
    } qitem_t;

    typedef struct packed {
        logic [8:0] master_volume;
        logic       mute;
        logic       output_8bit;
        logic       output_stereo;
        logic [4:0] ring_size_log2;
    } cfg_t;

    function automatic logic signed [16:0] scale_contrib(
        input logic               mode,
        input logic signed [15:0] sample,
        input logic [7:0]         vol
    );
        logic signed [24:0] prod16;
        logic signed [13:0] prod8;
        prod16 = sample * $signed({1'b0, vol});
        prod8  = $signed(sample[7:0]) * $signed({1'b0, vol[7:3]});
        if (mode)
            return $signed({prod8, 3'b000});
        return prod16[24:8];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        if (v > 25'(SUM_MAX))
            return SUM_MAX;
        if (v < 25'(SUM_MIN))
            return SUM_MIN;
        return v[23:0];
    endfunction

    function automatic logic [15:0] finish(
        input logic signed [32:0] prod,
        input logic               output_8bit
    );
        logic signed [24:0] v;
        logic [15:0]        s16;
        v = prod[32:8];
        if (v > OUT_MAX)
            s16 = 16'h7fff;
        else if (v < OUT_MIN)
            s16 = 16'h8000;
        else
            s16 = v[15:0];
        if (output_8bit)
            return {8'd0, ~s16[15], s16[14:8]};
        return s16;
    endfunction

endpackage

`default_nettype wire

@@ rtl/smix_front.sv @@
// ----------------------------------------------------------------------------
// smix_front
// Takes input beats and turns each into its scaled left and right parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smix_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire smix_pkg::item_t item,
    input  wire logic            q_full,
    output logic                 q_push,
    output smix_pkg::qitem_t     q_data
);
    import smix_pkg::*;

    logic   stage_valid_reg;
    logic   stage_valid_next;
    qitem_t stage_reg;
    qitem_t stage_next;
    logic   accept;

    assign full   = stage_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = stage_valid_reg && !q_full;
    assign q_data = stage_reg;

    always_comb
    begin
        stage_valid_next     = accept || (stage_valid_reg && q_full);
        stage_next           = stage_reg;
        if (accept)
        begin
            stage_next.contrib_l = scale_contrib(item.mode, item.sample, item.left_volume);
            stage_next.contrib_r = scale_contrib(item.mode, item.sample, item.right_volume);
            stage_next.last      = item.last_in_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

endmodule

`default_nettype wire

@@ rtl/smix_queue.sv @@
// ----------------------------------------------------------------------------
// smix_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smix_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire smix_pkg::qitem_t data_in,
    output logic                  full,
    input  wire logic             pop,
    output smix_pkg::qitem_t      data_out,
    output logic                  empty
);
    import smix_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qitem_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= data_in;
    end

endmodule

`default_nettype wire

@@ rtl/smix_back.sv @@
// ----------------------------------------------------------------------------
// smix_back
// Accumulates the queued parts and closes each frame into one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smix_back #(
    parameter int ADDR_WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire smix_pkg::cfg_t   cfg,
    input  wire logic             q_empty,
    input  wire smix_pkg::qitem_t q_data,
    output logic                  q_pop,
    output logic                  empty,
    input  wire logic             pop,
    output smix_pkg::result_t     result
);
    import smix_pkg::*;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_SCALE,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic signed [23:0] lsum_reg;
    logic signed [23:0] lsum_next;
    logic signed [23:0] rsum_reg;
    logic signed [23:0] rsum_next;
    logic signed [32:0] lprod_reg;
    logic signed [32:0] lprod_next;
    logic signed [32:0] rprod_reg;
    logic signed [32:0] rprod_next;
    logic [15:0]        wpos_reg;
    logic [15:0]        wpos_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            result_reg;
    result_t            result_next;
    logic [8:0]         vol;
    logic [4:0]         lg;
    logic [16:0]        mask;
    logic [15:0]        addr_raw;

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        if (cfg.mute)
            vol = '0;
        else if (cfg.master_volume > UNITY_VOLUME)
            vol = UNITY_VOLUME;
        else
            vol = cfg.master_volume;

        if (cfg.ring_size_log2 == '0)
            lg = 5'd1;
        else if (cfg.ring_size_log2 > 5'(ADDR_WIDTH))
            lg = 5'(ADDR_WIDTH);
        else
            lg = cfg.ring_size_log2;
        mask     = (17'd1 << lg) - 17'd1;
        addr_raw = cfg.output_stereo ? {wpos_reg[14:0], 1'b0} : wpos_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        lsum_next      = lsum_reg;
        rsum_next      = rsum_reg;
        lprod_next     = lprod_reg;
        rprod_next     = rprod_reg;
        wpos_next      = wpos_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        q_pop          = 1'b0;

        if (pop && out_valid_reg)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_ACC:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    lsum_next = sat24(25'(lsum_reg) + 25'(q_data.contrib_l));
                    rsum_next = sat24(25'(rsum_reg) + 25'(q_data.contrib_r));
                    if (q_data.last)
                        state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                lprod_next = lsum_reg * $signed({1'b0, vol});
                rprod_next = rsum_reg * $signed({1'b0, vol});
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next        = 1'b1;
                    result_next.address   = addr_raw & mask[15:0];
                    result_next.left_out  = finish(lprod_reg, cfg.output_8bit);
                    result_next.right_out = cfg.output_stereo ?
                                            finish(rprod_reg, cfg.output_8bit) : '0;
                    lsum_next             = '0;
                    rsum_next             = '0;
                    wpos_next             = wpos_reg + 1'b1;
                    state_next            = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            lsum_reg      <= '0;
            rsum_reg      <= '0;
            lprod_reg     <= '0;
            rprod_reg     <= '0;
            wpos_reg      <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lsum_reg      <= lsum_next;
            rsum_reg      <= rsum_next;
            lprod_reg     <= lprod_next;
            rprod_reg     <= rprod_next;
            wpos_reg      <= wpos_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/stereo_sound_mixer.sv @@
// ----------------------------------------------------------------------------
// stereo_sound_mixer
// Channel mixer with per-channel volume, master volume and saturation.
// ----------------------------------------------------------------------------
//   Channel   Handshake           Payload
//   input     push / full         item   (item_t)
//   result    empty / pop         result (result_t)
//   config    cfg_write           cfg_index, cfg_data
//
// One input beat can be taken every cycle while full is low; the per-channel
// multiplies sit in the front stage and feed the queue. The back part adds one
// queued beat per cycle while it accumulates and the queue is not empty. When
// a frame closes it moves on to the master-volume multiply and then to the
// result register, where it waits until the previous result has been popped.
// Reset clears the accumulators, the frame position and all handshake state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_sound_mixer #(
    parameter int ADDR_WIDTH  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire smix_pkg::item_t                     item,
    output logic                                     empty,
    input  wire logic                                pop,
    output smix_pkg::result_t                        result,
    input  wire logic                                cfg_write,
    input  wire logic [smix_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [smix_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import smix_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   q_push;
    logic   q_full;
    qitem_t q_in;
    logic   q_pop;
    logic   q_empty;
    qitem_t q_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MASTER_VOLUME:  cfg_next.master_volume  = cfg_data;
                CFG_MUTE:           cfg_next.mute           = cfg_data[0];
                CFG_OUTPUT_8BIT:    cfg_next.output_8bit    = cfg_data[0];
                CFG_OUTPUT_STEREO:  cfg_next.output_stereo  = cfg_data[0];
                CFG_RING_SIZE_LOG2: cfg_next.ring_size_log2 = cfg_data[4:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_volume  <= MASTER_VOLUME_RESET;
            cfg_reg.mute           <= 1'b0;
            cfg_reg.output_8bit    <= 1'b0;
            cfg_reg.output_stereo  <= 1'b1;
            cfg_reg.ring_size_log2 <= RING_SIZE_LOG2_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    smix_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    smix_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_out),
        .empty    (q_empty)
    );

    smix_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ rtl/smix_checker.sv @@
// ----------------------------------------------------------------------------
// smix_checker
// Port-level checks on the mixer, attached to every instance of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_sound_mixer_assert.svh"

module smix_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              push,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire smix_pkg::result_t result
);
    import smix_pkg::*;

    `SMIX_ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty && $stable(result))
    `SMIX_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !empty, empty)
    `SMIX_ASSERT_IMP(a_full_needs_push, clk, rst_n, $rose(full), $past(push))
    `SMIX_ASSERT_IMP(a_clean_start, clk, rst_n, $rose(rst_n), empty && !full)

endmodule

bind stereo_sound_mixer smix_checker u_checker (.*);

`default_nettype wire
